/* hdl/qspd_pkg.sv */
// Package for the query string percent decoder: parser phase codes, item kinds,
// status codes, character constants, hex decoding and the result header type.
// No dependencies; every other file but qspd_fifo and the file list uses it.
`timescale 1ns / 1ps
`default_nettype none

package qspd_pkg;

    localparam int LENGTH_BITS_DEF = 12;

    // Parser phase codes.
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_START = 3'd0;
    localparam logic [PHASE_W-1:0] PH_NAME  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_VALUE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ESC1  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_ESC2  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SKIP  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_STOP  = 3'd6;

    // Result item kinds.
    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Parameter end status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADESC = 2'd1;
    localparam logic [1:0] ST_NOEQ   = 2'd2;

    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    // Everything of a result item except its length.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } t_res_hdr;

    localparam t_res_hdr RES_NONE = '{kind: KIND_NAME, data: 8'd0, status: ST_OK, last: 1'b0};

    // Returns {is_hex, digit value}.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            // Letters a..f and A..F share their low three bits: 1..6.
            r = {1'b1, 4'(c[2:0] + 3'd1) + 4'd8};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/qspd_if.sv */
// Handshake channel interfaces for the query string percent decoder:
// one for raw input items and one for result items.
// Depends on qspd_pkg for the default length width.
`timescale 1ns / 1ps
`default_nettype none

interface qspd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface qspd_out_if #(
    parameter int LENGTH_BITS = qspd_pkg::LENGTH_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             item_kind;
    logic [7:0]             data_byte;
    logic [1:0]             param_status;
    logic [LENGTH_BITS-1:0] decoded_length;
    logic                   run_last;

    modport source (output valid, output item_kind, output data_byte, output param_status,
                    output decoded_length, output run_last, input ready);
    modport sink (input valid, input item_kind, input data_byte, input param_status,
                  input decoded_length, input run_last, output ready);
endinterface

`default_nettype wire

/* hdl/query_string_percent_decoder_core.sv */
// Query string percent decoder, one raw byte per input item.
// A result item is offered from the result queue once its input item has left the input
// register; a full queue holds that item there. Throughput: one input item per cycle
// while the receiver takes results and each byte yields at most one result; a byte that
// yields two results needs two transfers on the single-item result port.
// Reset (i_rst_n low, synchronous): parser to start of segment, length and queue cleared.
// Depends on qspd_pkg, qspd_if, qspd_step and qspd_fifo.
`timescale 1ns / 1ps
`default_nettype none

module query_string_percent_decoder_core #(
    parameter int LENGTH_BITS = qspd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qspd_in_if.sink    i_in,
    qspd_out_if.source o_out
);
    import qspd_pkg::*;

    localparam int HDR_W = $bits(t_res_hdr);
    localparam int RES_W = HDR_W + LENGTH_BITS;

    // Input register.
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_eos;

    // Parser state.
    logic [PHASE_W-1:0]     r_phase;
    logic [PHASE_W-1:0]     n_phase;
    logic [3:0]             r_first_hex;
    logic [3:0]             n_first_hex;
    logic [LENGTH_BITS-1:0] r_len;
    logic [LENGTH_BITS-1:0] n_len;

    logic [1:0]             res_count;
    t_res_hdr               res0;
    t_res_hdr               res1;
    logic [LENGTH_BITS-1:0] len0;
    logic [LENGTH_BITS-1:0] len1;
    logic                   room2;
    logic                   consume;
    logic                   accept;
    logic [RES_W-1:0]       q_data;
    t_res_hdr               q_hdr;

    assign consume    = r_in_valid && room2;
    assign i_in.ready = !r_in_valid || room2;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in.in_byte;
            r_in_eos  <= i_in.end_of_string;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_first_hex <= 4'd0;
            r_len       <= '0;
        end else if (consume) begin
            r_phase     <= n_phase;
            r_first_hex <= n_first_hex;
            r_len       <= n_len;
        end
    end

    qspd_step #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_step (
        .i_phase    (r_phase),
        .i_first_hex(r_first_hex),
        .i_len      (r_len),
        .i_byte     (r_in_byte),
        .i_last     (r_in_eos),
        .o_phase    (n_phase),
        .o_first_hex(n_first_hex),
        .o_len      (n_len),
        .o_count    (res_count),
        .o_res0     (res0),
        .o_res1     (res1),
        .o_len0     (len0),
        .o_len1     (len1)
    );

    qspd_fifo #(
        .WIDTH(RES_W)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (consume ? res_count : 2'd0),
        .i_data0({res0, len0}),
        .i_data1({res1, len1}),
        .i_pop  (o_out.ready),
        .o_valid(o_out.valid),
        .o_data (q_data),
        .o_room2(room2)
    );

    assign q_hdr                = t_res_hdr'(q_data[RES_W-1:LENGTH_BITS]);
    assign o_out.item_kind      = q_hdr.kind;
    assign o_out.data_byte      = q_hdr.data;
    assign o_out.param_status   = q_hdr.status;
    assign o_out.run_last       = q_hdr.last;
    assign o_out.decoded_length = q_data[LENGTH_BITS-1:0];

    a_eos_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in_eos) |=> (r_phase == PH_START && r_len == '0 && r_first_hex == 4'd0))
        else $error("parser not back at segment start after final byte");

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_STOP)
        else $error("parser phase holds an unused code");

    a_skip_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_phase == PH_SKIP && r_in_byte != CH_AMP && !r_in_eos)
        |=> (r_phase == PH_SKIP))
        else $error("skip phase left without a separator");

    a_stop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STOP || r_phase == PH_SKIP) |-> (res_count == 2'd0))
        else $error("results produced while skipping or stopped");

endmodule

`default_nettype wire

/* hdl/qspd_step.sv */
// Next-state and result logic of the decoder for one raw byte.
// Purely combinational; depends on qspd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qspd_step #(
    parameter int LENGTH_BITS = qspd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic [qspd_pkg::PHASE_W-1:0] i_phase,
    input  wire logic [3:0]                   i_first_hex,
    input  wire logic [LENGTH_BITS-1:0]       i_len,
    input  wire logic [7:0]                   i_byte,
    input  wire logic                         i_last,
    output logic      [qspd_pkg::PHASE_W-1:0] o_phase,
    output logic      [3:0]                   o_first_hex,
    output logic      [LENGTH_BITS-1:0]       o_len,
    output logic      [1:0]                   o_count,
    output qspd_pkg::t_res_hdr                o_res0,
    output qspd_pkg::t_res_hdr                o_res1,
    output logic      [LENGTH_BITS-1:0]       o_len0,
    output logic      [LENGTH_BITS-1:0]       o_len1
);
    import qspd_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic [4:0]             hex;
    logic                   is_hex;
    logic [LENGTH_BITS-1:0] len_inc;
    logic [7:0]             value;

    assign hex     = hex_decode(i_byte);
    assign is_hex  = hex[4];
    assign len_inc = (i_len == LEN_MAX) ? i_len : i_len + LENGTH_BITS'(1);
    assign value   = (i_phase == PH_ESC2) ? {i_first_hex, hex[3:0]} : i_byte;

    always_comb begin
        o_phase     = i_phase;
        o_first_hex = i_first_hex;
        o_len       = i_len;
        o_count     = 2'd0;
        o_res0      = RES_NONE;
        o_res1      = RES_NONE;
        o_len0      = '0;
        o_len1      = '0;
        case (i_phase)
            PH_START, PH_NAME: begin
                if (i_byte == CH_EQUALS) begin
                    o_phase = PH_VALUE;
                    o_len   = '0;
                    if (i_last) begin
                        o_res0.kind = KIND_END;
                        o_count     = 2'd1;
                    end
                end else if (i_byte == CH_AMP) begin
                    o_res0.kind   = KIND_END;
                    o_res0.status = ST_NOEQ;
                    o_count       = 2'd1;
                    o_phase       = PH_STOP;
                    o_len         = '0;
                end else begin
                    o_res0.kind = KIND_NAME;
                    o_res0.data = i_byte;
                    o_phase     = PH_NAME;
                    o_count     = 2'd1;
                    if (i_last) begin
                        o_res1.kind   = KIND_END;
                        o_res1.status = ST_NOEQ;
                        o_count       = 2'd2;
                    end
                end
            end
            PH_VALUE: begin
                if (i_byte == CH_AMP) begin
                    o_res0.kind = KIND_END;
                    o_len0      = i_len;
                    o_count     = 2'd1;
                    o_len       = '0;
                    o_phase     = PH_START;
                end else if (i_byte == CH_PERCENT) begin
                    o_phase = PH_ESC1;
                    if (i_last) begin
                        o_res0.kind   = KIND_END;
                        o_res0.status = ST_BADESC;
                        o_count       = 2'd1;
                    end
                end else begin
                    o_res0.kind = KIND_VALUE;
                    o_res0.data = i_byte;
                    o_len       = len_inc;
                    o_count     = 2'd1;
                    if (i_last) begin
                        o_res1.kind = KIND_END;
                        o_len1      = len_inc;
                        o_count     = 2'd2;
                    end
                end
            end
            PH_ESC1, PH_ESC2: begin
                // A double percent sign in the first escape position is a literal.
                if ((i_phase == PH_ESC1 && i_byte == CH_PERCENT)
                        || (i_phase == PH_ESC2 && is_hex)) begin
                    o_res0.kind = KIND_VALUE;
                    o_res0.data = value;
                    o_len       = len_inc;
                    o_phase     = PH_VALUE;
                    o_count     = 2'd1;
                    if (i_last) begin
                        o_res1.kind = KIND_END;
                        o_len1      = len_inc;
                        o_count     = 2'd2;
                    end
                end else if (i_phase == PH_ESC1 && is_hex && !i_last) begin
                    o_first_hex = hex[3:0];
                    o_phase     = PH_ESC2;
                end else begin
                    o_res0.kind   = KIND_END;
                    o_res0.status = ST_BADESC;
                    o_count       = 2'd1;
                    o_len         = '0;
                    o_phase       = (i_byte == CH_AMP) ? PH_START : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (i_byte == CH_AMP) begin
                    o_phase = PH_START;
                    o_len   = '0;
                end
            end
            default: begin
            end
        endcase

        o_res0.last = (o_count == 2'd1);
        o_res1.last = (o_count == 2'd2);

        // The final byte of a string returns the parser to its reset state.
        if (i_last) begin
            o_phase     = PH_START;
            o_first_hex = 4'd0;
            o_len       = '0;
        end
    end

endmodule

`default_nettype wire

/* hdl/qspd_fifo.sv */
// Four-entry result queue that takes up to two items per cycle and
// gives one item per cycle. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module qspd_fifo #(
    parameter int WIDTH = 25
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [1:0]       i_push,
    input  wire logic [WIDTH-1:0] i_data0,
    input  wire logic [WIDTH-1:0] i_data1,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_room2
);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    r_rd;
    logic [AW-1:0]    n_rd;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room2 = (r_count <= CW'(DEPTH - 2));
    assign pop     = i_pop && o_valid;
    assign n_wr    = r_wr + AW'(i_push);
    assign n_rd    = r_rd + AW'(pop);
    assign n_count = r_count + CW'(i_push) - CW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wr + AW'(1)] <= i_data1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push != 2'd0) |-> ((r_count + CW'(i_push)) <= CW'(DEPTH)))
        else $error("result queue written while full");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push == 2'd0 && !pop) |=> $stable(r_count))
        else $error("result queue count moved without push or pop");

endmodule

`default_nettype wire

/* bench/query_string_percent_decoder_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for query_string_percent_decoder_core: random and directed query strings
// go in through qspd_in_if, a local predictor checks every item that comes out of qspd_out_if.
// Depends on qspd_pkg, qspd_if and the block's RTL.

module query_string_percent_decoder_core_tb;
    import qspd_pkg::*;

    localparam int LEN_W        = LENGTH_BITS_DEF;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam int STUCK_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 2000;
    localparam int LONG_VALUE   = 200;

    typedef struct {
        logic [7:0] b;
        logic       eos;
        bit         pause;
    } src_item_t;

    typedef struct {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [1:0]       status;
        logic [LEN_W-1:0] len;
        logic             last;
    } dec_res_t;

    logic i_clk;
    logic i_rst_n;

    qspd_in_if in_if ();
    qspd_out_if #(.LENGTH_BITS(LEN_W)) out_if ();

    query_string_percent_decoder_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    src_item_t pending[$];
    dec_res_t  exp_items[$];

    int n_in_acc;
    int n_out_acc;
    int total_in;
    int n_fail;
    int stuck_cycles;
    int hold_left;
    bit hold_done;

    // Predictor state.
    logic [PHASE_W-1:0] ps_phase;
    logic [3:0]         ps_hi;
    logic [LEN_W-1:0]   ps_len;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int hex_digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    // Three idle profiles in a row, chosen by how far the input stream has got.
    function automatic int stage_of();
        if (n_in_acc < total_in / 3) return 0;
        if (n_in_acc < (2 * total_in) / 3) return 1;
        return 2;
    endfunction

    function automatic int src_idle_pct();
        case (stage_of())
            0: return 13;
            1: return 88;
            default: return 0;
        endcase
    endfunction

    function automatic int dst_idle_pct();
        case (stage_of())
            0: return 88;
            1: return 13;
            default: return 0;
        endcase
    endfunction

    function automatic string fmt_res(input logic [1:0] kind, input logic [7:0] data,
                                      input logic [1:0] status, input logic [LEN_W-1:0] len,
                                      input logic last);
        return $sformatf("kind %0d data %02h status %0d len %0d last %0d",
                         kind, data, status, len, last);
    endfunction

    // ---------------------------------------------------------------- predictor

    task emit(input logic [1:0] kind, input logic [7:0] data, input logic [1:0] status,
              input logic [LEN_W-1:0] len);
        dec_res_t r;
        r.kind   = kind;
        r.data   = data;
        r.status = status;
        r.len    = len;
        r.last   = 1'b0;
        exp_items.insert(exp_items.size(), r);
    endtask

    task put_value(input logic [7:0] b);
        emit(KIND_VALUE, b, ST_OK, '0);
        if (ps_len != LEN_MAX) ps_len = ps_len + 1'b1;
    endtask

    task end_param(input logic [1:0] status);
        emit(KIND_END, 8'd0, status, (status == ST_OK) ? ps_len : '0);
        ps_len = '0;
    endtask

    task decode_byte(input logic [7:0] b, input logic eos);
        int       base;
        int       hv;
        dec_res_t r;
        base = exp_items.size();
        hv   = hex_digit_of(b);
        case (ps_phase)
            PH_START, PH_NAME: begin
                if (b == CH_EQUALS) begin
                    ps_phase = PH_VALUE;
                    ps_len   = '0;
                    if (eos) end_param(ST_OK);
                end else if (b == CH_AMP) begin
                    end_param(ST_NOEQ);
                    ps_phase = PH_STOP;
                end else begin
                    emit(KIND_NAME, b, ST_OK, '0);
                    ps_phase = PH_NAME;
                    if (eos) end_param(ST_NOEQ);
                end
            end
            PH_VALUE: begin
                if (b == CH_AMP) begin
                    end_param(ST_OK);
                    ps_phase = PH_START;
                end else if (b == CH_PERCENT) begin
                    ps_phase = PH_ESC1;
                    if (eos) end_param(ST_BADESC);
                end else begin
                    put_value(b);
                    if (eos) end_param(ST_OK);
                end
            end
            PH_ESC1: begin
                if (b == CH_PERCENT) begin
                    put_value(b);
                    ps_phase = PH_VALUE;
                    if (eos) end_param(ST_OK);
                end else if (hv >= 0 && !eos) begin
                    ps_hi    = 4'(hv);
                    ps_phase = PH_ESC2;
                end else begin
                    end_param(ST_BADESC);
                    ps_phase = (b == CH_AMP) ? PH_START : PH_SKIP;
                end
            end
            PH_ESC2: begin
                if (hv >= 0) begin
                    put_value({ps_hi, 4'(hv)});
                    ps_phase = PH_VALUE;
                    if (eos) end_param(ST_OK);
                end else begin
                    end_param(ST_BADESC);
                    ps_phase = (b == CH_AMP) ? PH_START : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (b == CH_AMP) begin
                    ps_phase = PH_START;
                    ps_len   = '0;
                end
            end
            default: begin
            end
        endcase
        if (exp_items.size() > base) begin
            r = exp_items[exp_items.size() - 1];
            r.last = 1'b1;
            exp_items[exp_items.size() - 1] = r;
        end
        if (eos) begin
            ps_phase = PH_START;
            ps_hi    = 4'd0;
            ps_len   = '0;
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    task push_byte(input logic [7:0] b, input logic eos);
        src_item_t it;
        it.b     = b;
        it.eos   = eos;
        it.pause = 1'b0;
        pending.insert(pending.size(), it);
    endtask

    task push_pause();
        src_item_t it;
        it.b     = 8'd0;
        it.eos   = 1'b0;
        it.pause = 1'b1;
        pending.insert(pending.size(), it);
    endtask

    task push_str(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_AMP || b == CH_PERCENT);
        return b;
    endfunction

    function automatic logic [7:0] rand_name_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_AMP || b == CH_EQUALS);
        return b;
    endfunction

    function automatic logic [7:0] rand_junk();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_AMP);
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'(8'h30 + v);
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
    endfunction

    // A byte that breaks an escape; '%' only counts as breaking in the second digit.
    function automatic logic [7:0] rand_non_hex(input bit pct_ok);
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) return CH_AMP;
        do b = 8'($urandom_range(0, 255));
        while (hex_digit_of(b) >= 0 || (!pct_ok && b == CH_PERCENT));
        return b;
    endfunction

    task automatic push_query(ref logic [7:0] qs[$]);
        for (int i = 0; i < qs.size(); i++) push_byte(qs[i], i == qs.size() - 1);
    endtask

    task automatic gen_value(ref logic [7:0] qs[$], input int vlen);
        int r;
        for (int i = 0; i < vlen; i++) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                qs.insert(qs.size(), rand_plain());
            end else if (r < 85) begin
                qs.insert(qs.size(), CH_PERCENT);
                qs.insert(qs.size(), hex_char($urandom_range(0, 15)));
                qs.insert(qs.size(), hex_char($urandom_range(0, 15)));
            end else if (r < 92) begin
                qs.insert(qs.size(), CH_PERCENT);
                qs.insert(qs.size(), CH_PERCENT);
            end else begin
                qs.insert(qs.size(), CH_EQUALS);
            end
        end
    endtask

    task automatic gen_query();
        logic [7:0] qs[$];
        int nseg;
        int kind;
        int sub;
        bit cut;
        nseg = $urandom_range(1, 4);
        cut  = 1'b0;
        for (int k = 0; k < nseg && !cut; k++) begin
            if (k > 0) qs.insert(qs.size(), CH_AMP);
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                repeat ($urandom_range(0, 4)) qs.insert(qs.size(), rand_name_byte());
                qs.insert(qs.size(), CH_EQUALS);
                gen_value(qs, $urandom_range(0, 8));
            end else if (kind < 87) begin
                repeat ($urandom_range(0, 3)) qs.insert(qs.size(), rand_name_byte());
                qs.insert(qs.size(), CH_EQUALS);
                gen_value(qs, $urandom_range(0, 3));
                qs.insert(qs.size(), CH_PERCENT);
                sub = $urandom_range(0, 2);
                if (sub == 0) begin
                    qs.insert(qs.size(), rand_non_hex(1'b0));
                end else if (sub == 1) begin
                    qs.insert(qs.size(), hex_char($urandom_range(0, 15)));
                    qs.insert(qs.size(), rand_non_hex(1'b1));
                end else begin
                    // Escape cut short by the end of the string.
                    if ($urandom_range(0, 1))
                        qs.insert(qs.size(), hex_char($urandom_range(0, 15)));
                    cut = 1'b1;
                end
                if (!cut) repeat ($urandom_range(0, 4)) qs.insert(qs.size(), rand_junk());
            end else if (kind < 94) begin
                repeat ($urandom_range(0, 4)) qs.insert(qs.size(), rand_name_byte());
            end else begin
                repeat ($urandom_range(1, 6))
                    qs.insert(qs.size(), 8'($urandom_range(0, 255)));
            end
        end
        if (!cut && $urandom_range(0, 9) == 0) qs.insert(qs.size(), CH_AMP);
        if (qs.size() == 0) qs.insert(qs.size(), 8'($urandom_range(0, 255)));
        push_query(qs);
    endtask

    task automatic gen_long_value();
        logic [7:0] qs[$];
        qs.insert(qs.size(), 8'h4C);
        qs.insert(qs.size(), CH_EQUALS);
        repeat (LONG_VALUE) qs.insert(qs.size(), rand_plain());
        push_query(qs);
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin : drv
        src_item_t nx;
        if (!i_rst_n) begin
            in_if.valid         <= 1'b0;
            in_if.in_byte       <= 8'd0;
            in_if.end_of_string <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            // A pause holds the stream until every outstanding result is back.
            if (pending.size() != 0 && pending[0].pause && !in_if.valid && exp_items.size() == 0)
                pending.delete(0);
            if (pending.size() != 0 && !pending[0].pause &&
                $urandom_range(0, 99) >= src_idle_pct()) begin
                nx = pending.pop_front();
                in_if.valid         <= 1'b1;
                in_if.in_byte       <= nx.b;
                in_if.end_of_string <= nx.eos;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin : mon
        dec_res_t want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            n_in_acc     <= 0;
            n_out_acc    <= 0;
            ps_phase      = PH_START;
            ps_hi         = 4'd0;
            ps_len        = '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                decode_byte(in_if.in_byte, in_if.end_of_string);
                n_in_acc <= n_in_acc + 1;
            end
            if (out_if.valid && out_if.ready) begin
                n_out_acc <= n_out_acc + 1;
                if (exp_items.size() == 0) begin
                    if (n_fail < 10)
                        $display("result %0d unexpected: %s", n_out_acc,
                                 fmt_res(out_if.item_kind, out_if.data_byte,
                                         out_if.param_status, out_if.decoded_length,
                                         out_if.run_last));
                    n_fail = n_fail + 1;
                end else begin
                    want = exp_items.pop_front();
                    if (out_if.item_kind !== want.kind || out_if.data_byte !== want.data ||
                        out_if.param_status !== want.status ||
                        out_if.decoded_length !== want.len || out_if.run_last !== want.last) begin
                        if (n_fail < 10)
                            $display("result %0d: expected %s, got %s", n_out_acc,
                                     fmt_res(want.kind, want.data, want.status, want.len,
                                             want.last),
                                     fmt_res(out_if.item_kind, out_if.data_byte,
                                             out_if.param_status, out_if.decoded_length,
                                             out_if.run_last));
                        n_fail = n_fail + 1;
                    end
                end
            end
            out_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= dst_idle_pct());
        end
    end

    // One long receiver hold-off, so the block backs up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_in_acc >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            stuck_cycles <= 0;
        else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // ---------------------------------------------------------------- sequence

    initial begin : main
        bit timed_out;
        bit long_done;
        in_if.valid         = 1'b0;
        in_if.in_byte       = 8'd0;
        in_if.end_of_string = 1'b0;
        out_if.ready        = 1'b0;
        i_rst_n             = 1'b0;
        n_fail              = 0;
        total_in            = 1;
        ps_phase            = PH_START;
        ps_hi               = 4'd0;
        ps_len              = '0;

        // Escapes in both cases, "%%" and a stray '=' in the value.
        push_str("a=%4A%f0%%=");
        // Non-hex after '%', then an escape cut by the end of the string.
        push_str("x=%g&y=%");
        // Empty segment, then a name with no '='.
        push_str("&");
        push_str("n");
        // Empty value at the end of the string.
        push_str("=");
        // Missing equals: everything after it is ignored.
        push_str("p&q");
        // Extreme byte values as name and value.
        push_byte(8'h00, 1'b0);
        push_byte(CH_EQUALS, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_pause();

        long_done = 1'b0;
        while (pending.size() < RANDOM_ITEMS) begin
            gen_query();
            if (!long_done && pending.size() > RANDOM_ITEMS / 2) begin
                // One long run of plain value bytes.
                gen_long_value();
                long_done = 1'b1;
            end
            if ($urandom_range(0, 19) == 0) push_pause();
        end
        total_in = 0;
        foreach (pending[i]) if (!pending[i].pause) total_in++;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        timed_out = 1'b0;
        while (!timed_out && !(pending.size() == 0 && !in_if.valid && exp_items.size() == 0)) begin
            @(posedge i_clk);
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("no item moved for %0d cycles", STUCK_LIMIT);
                timed_out = 1'b1;
            end
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (exp_items.size() != 0) begin
            $display("%0d expected result items never arrived", exp_items.size());
            n_fail = n_fail + 1;
        end
        if (!timed_out && n_fail == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
hdl/qspd_pkg.sv
hdl/qspd_if.sv
hdl/qspd_step.sv
hdl/qspd_fifo.sv
hdl/query_string_percent_decoder_core.sv
bench/query_string_percent_decoder_core_tb.sv
